FILE: rtl/tmlw_pkg.sv
// shared types and constants for the trimmed-mean latency window
package tmlw_pkg;

   localparam int DATA_W    = 16;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_LATENCY_ADDR = 2'd0;
   localparam logic [DATA_W-1:0]     MIN_LATENCY_RESET    = 16'd100;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_DRAIN = 6'b000100,
      ST_TRIM  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic trim_load;
      logic div_load;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } status_type;

endpackage

FILE: rtl/tmlw_ctrl.sv
// sequencer for window scan, trim, division and result hand-off
module tmlw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  tmlw_pkg::status_type sts,
   output tmlw_pkg::cmd_type    cmd
);
   import tmlw_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         // last read data lands in the accumulators here
         ST_DRAIN: begin
            state_in = ST_TRIM;
         end
         ST_TRIM: begin
            cmd.trim_load = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/tmlw_dp.sv
// window memory, min/max/sum scan, reciprocal-multiply divider and result register
module tmlw_dp #(
   parameter int WINDOW = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tmlw_pkg::cmd_type            cmd,
   output tmlw_pkg::status_type         sts,
   input  logic [tmlw_pkg::DATA_W-1:0]  sample,
   input  logic [tmlw_pkg::DATA_W-1:0]  min_latency,
   output logic [tmlw_pkg::DATA_W-1:0]  avg_latency
);
   import tmlw_pkg::*;

   localparam int AW      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W   = DATA_W + $clog2(WINDOW);
   localparam int DIVISOR = WINDOW - 2;
   localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
   localparam int PROD_W  = 2 * SUM_W + 1;
   // ceil(2^SHIFT / DIVISOR) gives the exact floor quotient for any SUM_W-bit sum
   localparam logic [SUM_W:0] RECIP =
      (SUM_W + 1)'(((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

   logic [DATA_W-1:0] mem [WINDOW];
   logic [WINDOW-1:0] valid_ff;
   logic [AW-1:0]     wptr_ff;
   logic [AW-1:0]     rd_cnt_ff;
   logic              rd_vld_ff;
   logic              entry_vld_ff;
   logic [DATA_W-1:0] rd_data_ff;

   logic [SUM_W-1:0]  sum_ff;
   logic [DATA_W-1:0] lo_ff;
   logic [DATA_W-1:0] hi_ff;

   logic [SUM_W-1:0]  trim_ff;
   logic [DATA_W-1:0] quo_ff;
   logic [DATA_W-1:0] result_ff;

   logic [DATA_W-1:0] elem;
   logic [SUM_W-1:0]  total;
   logic [PROD_W-1:0] prod;

   assign sts.scan_last = (rd_cnt_ff == AW'(WINDOW - 1));
   assign avg_latency   = result_ff;

   // entries never written since reset read as zero
   assign elem  = entry_vld_ff ? rd_data_ff : '0;
   assign total = sum_ff - SUM_W'(lo_ff) - SUM_W'(hi_ff);
   assign prod  = PROD_W'(trim_ff) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mem[wptr_ff] <= sample;
      end
      rd_data_ff   <= mem[rd_cnt_ff];
      entry_vld_ff <= valid_ff[rd_cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         wptr_ff   <= '0;
         rd_cnt_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan;
         if (cmd.load) begin
            valid_ff[wptr_ff] <= 1'b1;
            wptr_ff   <= (wptr_ff == AW'(WINDOW - 1)) ? '0 : wptr_ff + 1'b1;
            rd_cnt_ff <= '0;
         end else if (cmd.scan) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sum_ff <= '0;
         lo_ff  <= '1;
         hi_ff  <= '0;
      end else if (rd_vld_ff) begin
         sum_ff <= sum_ff + SUM_W'(elem);
         if (elem < lo_ff) begin
            lo_ff <= elem;
         end
         if (elem > hi_ff) begin
            hi_ff <= elem;
         end
      end
      if (cmd.trim_load) begin
         trim_ff <= total;
      end
      if (cmd.div_load) begin
         quo_ff <= prod[SHIFT +: DATA_W];
      end
      if (cmd.result_load) begin
         result_ff <= (quo_ff < min_latency) ? min_latency : quo_ff;
      end
   end

endmodule

FILE: rtl/trimmed_mean_latency_window_top.sv
// channel   | dir | width | contents
// req_      | in  | 16    | tdata[15:0] sample
// rsp_      | out | 16    | tdata[15:0] avg_latency
// csr_      | cfg | 32    | 0x0 min_latency[15:0]
// an item is accepted only in idle; its result becomes valid after a scan of the
// window memory through its single read port, a drain state, the trim, one reciprocal
// multiply and the result load.
// req_tready is high only while no item is in work; a finished item waits in the
// output register, so the next item is taken while rsp_ is stalled.
// reset clears the window to zeros and min_latency to 100; no clearing pass.
module trimmed_mean_latency_window_top #(
   parameter int WINDOW = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,   // [15:0] sample
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,   // [15:0] avg_latency
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tmlw_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tmlw_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tmlw_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import tmlw_pkg::*;

   cmd_type           cmd;
   status_type        sts;
   logic [DATA_W-1:0] min_latency_ff, min_latency_in;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == CSR_MIN_LATENCY_ADDR);
   assign min_latency_in = csr_wr ? csr_pwdata[DATA_W-1:0] : min_latency_ff;
   assign csr_prdata = (csr_paddr == CSR_MIN_LATENCY_ADDR)
                       ? CSR_DATA_W'(min_latency_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_latency_ff <= MIN_LATENCY_RESET;
      end else begin
         min_latency_ff <= min_latency_in;
      end
   end

   tmlw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tmlw_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .sample      (req_tdata),
      .min_latency (min_latency_ff),
      .avg_latency (rsp_tdata)
   );

endmodule
